// ----- src/snco_pkg.sv -----
// ---------------------------------------------------------------------------
// snco_pkg: shared constants and table function for the sine NCO
// Field widths of the frequency and scale words, the scale reset value and
// the quarter-wave sine table generator evaluated at elaboration.
// ---------------------------------------------------------------------------
package snco_pkg;

   localparam int unsigned FREQ_BITS    = 24;
   localparam int unsigned SCALE_BITS   = 32;
   localparam int unsigned PRODUCT_BITS = 48;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'd22906492;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // unsigned quotient by shift and subtract, only used while building the table
   function automatic logic [63:0] quotient_of(input logic [63:0] num,
                                               input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      int b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // one quarter-wave entry: round(sin(pi/2 * idx / 2^addr_bits) * full scale),
   // Taylor series in unsigned Q30, terms truncated, result rounded half up
   function automatic logic [63:0] sine_entry(input int unsigned idx,
                                              input int unsigned addr_bits,
                                              input int unsigned sample_bits);
      logic [63:0] amp;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] denom;
      logic [63:0] v;
      int unsigned k;
      amp = (64'd1 << (sample_bits - 1)) - 64'd1;
      x = (PI_HALF_Q30 * 64'(idx) + (64'd1 << (addr_bits - 1))) >> addr_bits;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (k = 1; k <= 7; k++) begin
         denom = 64'((2 * k) * (2 * k + 1));
         term = quotient_of((term * x2) >> 30, denom);
         if (k[0]) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum * amp + (64'd1 << 29)) >> 30;
      if (v > amp) begin
         v = amp;
      end
      return v;
   endfunction

endpackage

// ----- src/snco_step.sv -----
// ---------------------------------------------------------------------------
// snco_step: input register and phase step multiplier
// Registers the request beat, multiplies the frequency by the phase scale
// and registers the phase step for the accumulator stage.
// ---------------------------------------------------------------------------
module snco_step #(
   parameter int unsigned PHASE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [snco_pkg::FREQ_BITS-1:0]  req_freq_q8,
   input  logic                                   req_freq_valid,
   input  logic                                   csr_we,
   input  logic [snco_pkg::SCALE_BITS-1:0]        csr_wdata,
   output logic                                   step_valid,
   input  logic                                   step_ready,
   output logic                                   step_on,
   output logic [PHASE_BITS-1:0]                  step_value
);

   localparam int unsigned PROD_W = snco_pkg::FREQ_BITS + snco_pkg::SCALE_BITS + 1;
   localparam int unsigned SHIFT  = snco_pkg::PRODUCT_BITS - PHASE_BITS;

   logic [snco_pkg::SCALE_BITS-1:0]       scale_ff;
   logic                                  in_valid_ff;
   logic                                  in_on_ff;
   logic signed [snco_pkg::FREQ_BITS-1:0] in_freq_ff;
   logic                                  st_valid_ff;
   logic                                  st_on_ff;
   logic [PHASE_BITS-1:0]                 st_step_ff;
   logic [PHASE_BITS-1:0]                 st_step_in;
   logic signed [PROD_W-1:0]              product;
   logic                                  in_ready;
   logic                                  st_ready;

   // hold the phase scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= snco_pkg::SCALE_RESET;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   // each stage loads when empty or when its successor takes its beat
   assign st_ready  = !st_valid_ff || step_ready;
   assign in_ready  = !in_valid_ff || st_ready;
   assign req_ready = in_ready;

   // capture the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_freq_ff <= req_freq_q8;
         in_on_ff   <= req_freq_valid;
      end
   end

   // step = product shifted right, kept modulo the phase width
   assign product    = in_freq_ff * $signed({1'b0, scale_ff});
   assign st_step_in = product[snco_pkg::PRODUCT_BITS-1:SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (st_ready) begin
         st_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ready && in_valid_ff) begin
         st_step_ff <= st_step_in;
         st_on_ff   <= in_on_ff;
      end
   end

   assign step_valid = st_valid_ff;
   assign step_on    = st_on_ff;
   assign step_value = st_step_ff;

endmodule

// ----- src/snco_sine.sv -----
// ---------------------------------------------------------------------------
// snco_sine: phase accumulator, quarter-wave table and output register
// Looks up the sine of the current phase, advances the phase by the step
// and applies quadrant mirroring and sign before the response register.
// ---------------------------------------------------------------------------
module snco_sine #(
   parameter int unsigned PHASE_BITS      = 32,
   parameter int unsigned TABLE_ADDR_BITS = 10,
   parameter int unsigned SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_valid,
   output logic                          step_ready,
   input  logic                          step_on,
   input  logic [PHASE_BITS-1:0]         step_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_sample_valid
);

   localparam int unsigned QTR_LEN = 1 << TABLE_ADDR_BITS;
   localparam int unsigned IDX_LSB = PHASE_BITS - 2 - TABLE_ADDR_BITS;

   logic [SAMPLE_BITS-2:0]     quarter_rom [QTR_LEN+1];
   logic [PHASE_BITS-1:0]      phase_ff;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] idx;
   logic [TABLE_ADDR_BITS:0]   rom_addr;
   logic                       lk_valid_ff;
   logic                       lk_on_ff;
   logic                       lk_neg_ff;
   logic [SAMPLE_BITS-2:0]     lk_data_ff;
   logic                       out_valid_ff;
   logic                       out_on_ff;
   logic [SAMPLE_BITS-1:0]     out_sample_ff;
   logic [SAMPLE_BITS-1:0]     out_sample_in;
   logic [SAMPLE_BITS-1:0]     magnitude;
   logic                       lk_ready;
   logic                       out_ready;
   logic                       lk_load;

   // constant quarter-wave table, one entry per generate step
   for (genvar i = 0; i <= QTR_LEN; i++) begin : g_rom
      localparam logic [63:0] ENTRY =
         snco_pkg::sine_entry(i, TABLE_ADDR_BITS, SAMPLE_BITS);
      assign quarter_rom[i] = ENTRY[SAMPLE_BITS-2:0];
   end

   assign out_ready  = !out_valid_ff || rsp_ready;
   assign lk_ready   = !lk_valid_ff || out_ready;
   assign step_ready = lk_ready;
   assign lk_load    = step_valid && lk_ready;

   // mirror the index in odd quadrants
   assign quad     = phase_ff[PHASE_BITS-1:PHASE_BITS-2];
   assign idx      = phase_ff[PHASE_BITS-3:IDX_LSB];
   assign rom_addr = quad[0] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, idx})
                             : {1'b0, idx};

   // advance the phase only on an accepted beat that carries a valid frequency
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (lk_load && step_on) begin
         phase_ff <= phase_ff + step_value;
      end
   end

   // table read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff <= 1'b0;
      end else if (lk_ready) begin
         lk_valid_ff <= step_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_load) begin
         lk_data_ff <= quarter_rom[rom_addr];
         lk_neg_ff  <= quad[1];
         lk_on_ff   <= step_on;
      end
   end

   // apply sign, zero the sample of a beat without a valid frequency
   assign magnitude = {1'b0, lk_data_ff};
   always_comb begin
      if (!lk_on_ff) begin
         out_sample_in = '0;
      end else if (lk_neg_ff) begin
         out_sample_in = -magnitude;
      end else begin
         out_sample_in = magnitude;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= lk_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && lk_valid_ff) begin
         out_sample_ff <= out_sample_in;
         out_on_ff     <= lk_on_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sample       = out_sample_ff;
   assign rsp_sample_valid = out_on_ff;

endmodule

// ----- src/sine_phase_accumulator_oscillator_top.sv -----
// ---------------------------------------------------------------------------
// sine_phase_accumulator_oscillator_top: direct digital synthesis sine NCO
// Outputs the sine of the phase for each valid tick, then advances the
// phase accumulator by the shifted product of frequency and phase scale.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  request  | req_valid/ready    | req_freq_q8 (s24, Q15.8), req_freq_valid
//  response | rsp_valid/ready    | rsp_sample (sSAMPLE_BITS), rsp_sample_valid
//  config   | csr_we             | csr_wdata (phase scale, u32)
//
// One beat per cycle sustained while responses are taken; an accepted request
// beat passes the input register, multiplier register, table read and output.
// The phase add is a registered loop in the table-read stage.
// Reset clears the pipeline and the phase and loads the default scale.
// A stalled response holds each stage in turn; empty stages still fill.
// ---------------------------------------------------------------------------
module sine_phase_accumulator_oscillator_top #(
   parameter int unsigned PHASE_BITS      = 32,
   parameter int unsigned TABLE_ADDR_BITS = 10,
   parameter int unsigned SAMPLE_BITS     = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [snco_pkg::FREQ_BITS-1:0] req_freq_q8,
   input  logic                                  req_freq_valid,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample,
   output logic                                  rsp_sample_valid,
   input  logic                                  csr_we,
   input  logic [snco_pkg::SCALE_BITS-1:0]       csr_wdata
);

   logic                  step_valid;
   logic                  step_ready;
   logic                  step_on;
   logic [PHASE_BITS-1:0] step_value;

   // frequency to phase step
   snco_step #(
      .PHASE_BITS (PHASE_BITS)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_freq_q8    (req_freq_q8),
      .req_freq_valid (req_freq_valid),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .step_valid     (step_valid),
      .step_ready     (step_ready),
      .step_on        (step_on),
      .step_value     (step_value)
   );

   // phase accumulator and sine lookup
   snco_sine #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_sine (
      .clock            (clock),
      .reset            (reset),
      .step_valid       (step_valid),
      .step_ready       (step_ready),
      .step_on          (step_on),
      .step_value       (step_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_sample_valid (rsp_sample_valid)
   );

endmodule
